// ----- sv/ipru_pkg.sv -----
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types and constants for the integer pixel replicating upscaler.
// ----------------------------------------------------------------------------
package ipru_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int SCALE_REG_W = 7;
    localparam int WIDTH_REG_W = 11;
    localparam int PIXEL_W     = 24;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SCALE     = 1'b0;
    localparam t_cfg_idx CFG_SRC_WIDTH = 1'b1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       src_row_done;
    } t_out_item;

    typedef struct packed {
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       src_row_done;
    } t_out_meta;

endpackage

// ----- sv/integer_pixel_replicating_upscaler.sv -----
// ----------------------------------------------------------------------------
// integer_pixel_replicating_upscaler
// Nearest-neighbor integer upscaler: one source row is loaded into a line
// buffer, then replayed scale times horizontally and vertically.
// A tick transfer's result passes the buffer read register, then the output
// register. Throughput: one item per cycle unless the output stalls, set by
// the single line buffer read port. Reset clears all counters and sets scale
// and source width to 1; line buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
module integer_pixel_replicating_upscaler import ipru_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_out
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic               accept;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [PIXEL_W-1:0] wr_data, rd_data;
    t_out_meta          meta;

    logic      r_s1_valid, n_s1_valid;
    t_out_meta r_s1_meta;
    logic      r_out_valid;
    t_out_item r_out;
    logic      s1_adv;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    ipru_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_meta     (meta)
    );

    ipru_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (rd_en) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_meta <= meta;
        end
        if (s1_adv && r_s1_valid) begin
            r_out.out_blue     <= rd_data[7:0];
            r_out.out_green    <= rd_data[15:8];
            r_out.out_red      <= rd_data[23:16];
            r_out.row_end      <= r_s1_meta.row_end;
            r_out.pad_bytes    <= r_s1_meta.pad_bytes;
            r_out.src_row_done <= r_s1_meta.src_row_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ----- sv/ipru_ram.sv -----
// ----------------------------------------------------------------------------
// ipru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                    i_wr_data,
    input  logic                                i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/ipru_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipru_ctrl
// Configuration registers, load/emit counters and line buffer addressing.
// ----------------------------------------------------------------------------
module ipru_ctrl import ipru_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 64,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [PIXEL_W-1:0]    o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    output t_out_meta             o_meta
);

    localparam int LW = $clog2(MAX_WIDTH + 1) > 0 ? $clog2(MAX_WIDTH + 1) : 1;
    localparam int SW = $clog2(MAX_SCALE + 1) > 0 ? $clog2(MAX_SCALE + 1) : 1;
    localparam int CW = (LW > WIDTH_REG_W) ? LW : WIDTH_REG_W;
    localparam int KW = (SW > SCALE_REG_W) ? SW : SCALE_REG_W;

    logic [SCALE_REG_W-1:0] r_scale;
    logic [WIDTH_REG_W-1:0] r_src_width;
    logic [LW-1:0]          r_loaded, n_loaded;
    logic                   r_emitting, n_emitting;
    logic [LW-1:0]          r_col, n_col;
    logic [SW-1:0]          r_hcopy, n_hcopy;
    logic [SW-1:0]          r_vcopy, n_vcopy;

    logic [LW-1:0] eff_w;
    logic [SW-1:0] eff_s;
    logic [CW-1:0] width_ext;
    logic [KW-1:0] scale_ext;
    logic          do_load, do_tick;
    logic          can_store;
    logic [LW-1:0] loaded_inc;
    logic          last_copy, last_col, last_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_REG_W'(1);
            r_src_width <= WIDTH_REG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:     r_scale     <= i_cfg_data[SCALE_REG_W-1:0];
                CFG_SRC_WIDTH: r_src_width <= i_cfg_data[WIDTH_REG_W-1:0];
                default:       r_scale     <= r_scale;
            endcase
        end
    end

    always_comb begin
        width_ext = CW'(r_src_width);
        scale_ext = KW'(r_scale);
        if (width_ext == '0) begin
            eff_w = LW'(1);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            eff_w = LW'(MAX_WIDTH);
        end else begin
            eff_w = LW'(width_ext);
        end
        if (scale_ext == '0) begin
            eff_s = SW'(1);
        end else if (scale_ext > KW'(MAX_SCALE)) begin
            eff_s = SW'(MAX_SCALE);
        end else begin
            eff_s = SW'(scale_ext);
        end
    end

    assign do_load    = i_accept && (i_item.opcode == OP_LOAD) && !r_emitting;
    assign do_tick    = i_accept && (i_item.opcode == OP_TICK) && r_emitting;
    assign can_store  = r_loaded < eff_w;
    assign loaded_inc = r_loaded + LW'(1);
    assign last_copy  = (r_hcopy + SW'(1)) >= eff_s;
    assign last_col   = (r_col + LW'(1)) >= eff_w;
    assign last_vert  = (r_vcopy + SW'(1)) >= eff_s;

    always_comb begin
        n_loaded   = r_loaded;
        n_emitting = r_emitting;
        n_col      = r_col;
        n_hcopy    = r_hcopy;
        n_vcopy    = r_vcopy;
        o_meta     = '0;
        if (do_load) begin
            if (can_store) begin
                n_loaded = loaded_inc;
            end
            if (n_loaded >= eff_w) begin
                n_emitting = 1'b1;
            end
        end
        if (do_tick) begin
            o_meta.row_end = last_copy && last_col;
            if (last_copy && last_col) begin
                o_meta.pad_bytes = 2'(2'(eff_w) * 2'(eff_s));
            end
            if (!last_copy) begin
                n_hcopy = r_hcopy + SW'(1);
            end else begin
                n_hcopy = '0;
                if (!last_col) begin
                    n_col = r_col + LW'(1);
                end else begin
                    n_col = '0;
                    if (last_vert) begin
                        n_vcopy             = '0;
                        n_loaded            = '0;
                        n_emitting          = 1'b0;
                        o_meta.src_row_done = 1'b1;
                    end else begin
                        n_vcopy = r_vcopy + SW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_emitting <= 1'b0;
            r_col      <= '0;
            r_hcopy    <= '0;
            r_vcopy    <= '0;
        end else begin
            r_loaded   <= n_loaded;
            r_emitting <= n_emitting;
            r_col      <= n_col;
            r_hcopy    <= n_hcopy;
            r_vcopy    <= n_vcopy;
        end
    end

    assign o_wr_en   = do_load && can_store;
    assign o_wr_addr = r_loaded[AW-1:0];
    assign o_wr_data = {i_item.in_red, i_item.in_green, i_item.in_blue};
    assign o_rd_en   = do_tick;
    assign o_rd_addr = r_col[AW-1:0];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer pixel replicating upscaler. A clocked
// driver sends load and tick transfers from a queue, a clocked monitor checks
// each output pixel against an in-bench line buffer and copy counters, and
// both sides idle at random. Directed rows cover the register extremes and
// mid-row register changes; random rows follow with noise and cut rows.
// ----------------------------------------------------------------------------
module tb_top import ipru_pkg::*; ();

    localparam int MAX_W = 1024;
    localparam int MAX_S = 64;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    t_in_item              i_in;
    logic                  o_valid;
    logic                  i_stall;
    t_out_item             o_out;

    integer_pixel_replicating_upscaler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

    // line buffer shadow and copy counters
    logic [23:0]      line_px [MAX_W];
    logic [6:0]       scale_reg  = 7'd1;
    logic [10:0]      width_reg  = 11'd1;
    int               loaded     = 0;
    bit               emitting   = 0;
    int               col        = 0;
    int               hcopy      = 0;
    int               vcopy      = 0;
    int               high_water = 0;

    t_in_item  pend_items[$];
    t_out_item pixels_due[$];
    t_out_item due;

    bit in_fire    = 0;
    bit send_quiet = 0;
    bit recv_quiet = 0;
    bit hold_req   = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int n_stim     = 0;
    int n_fail     = 0;

    function automatic int eff_scale(int v);
        if (v == 0) return 1;
        if (v > MAX_S) return MAX_S;
        return v;
    endfunction

    function automatic int eff_width(int v);
        if (v == 0) return 1;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic upscale_step(input t_in_item it);
        int        w;
        int        s;
        int        nbytes;
        bit        last_h;
        bit        last_c;
        t_out_item r;
        w = eff_width(width_reg);
        s = eff_scale(scale_reg);
        if (it.opcode == OP_LOAD) begin
            if (!emitting) begin
                if (loaded < w) begin
                    line_px[loaded] = {it.in_red, it.in_green, it.in_blue};
                    loaded++;
                    if (loaded > high_water) high_water = loaded;
                end
                if (loaded >= w) emitting = 1;
            end
        end else if (emitting) begin
            r = '0;
            {r.out_red, r.out_green, r.out_blue} = line_px[col];
            last_h = (hcopy + 1 >= s);
            last_c = (col + 1 >= w);
            r.row_end = last_h && last_c;
            if (r.row_end) begin
                nbytes = w * s * 3;
                r.pad_bytes = 2'((4 - (nbytes % 4)) % 4);
            end
            if (!last_h) begin
                hcopy++;
            end else begin
                hcopy = 0;
                if (!last_c) begin
                    col++;
                end else begin
                    col = 0;
                    if (vcopy + 1 >= s) begin
                        vcopy = 0;
                        loaded = 0;
                        emitting = 0;
                        r.src_row_done = 1'b1;
                    end else begin
                        vcopy++;
                    end
                end
            end
            pixels_due.push_back(r);
        end
    endtask

    // monitor, then prediction for the transfer taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixels_due.size() == 0) begin
                $error("output pixel with none expected: %h", o_out);
                n_fail++;
            end else begin
                due = pixels_due.pop_front();
                if (o_out.out_blue !== due.out_blue) begin
                    $error("out_blue: expected %0d, got %0d", due.out_blue, o_out.out_blue);
                    n_fail++;
                end
                if (o_out.out_green !== due.out_green) begin
                    $error("out_green: expected %0d, got %0d", due.out_green, o_out.out_green);
                    n_fail++;
                end
                if (o_out.out_red !== due.out_red) begin
                    $error("out_red: expected %0d, got %0d", due.out_red, o_out.out_red);
                    n_fail++;
                end
                if (o_out.row_end !== due.row_end) begin
                    $error("row_end: expected %0d, got %0d", due.row_end, o_out.row_end);
                    n_fail++;
                end
                if (o_out.pad_bytes !== due.pad_bytes) begin
                    $error("pad_bytes: expected %0d, got %0d", due.pad_bytes, o_out.pad_bytes);
                    n_fail++;
                end
                if (o_out.src_row_done !== due.src_row_done) begin
                    $error("src_row_done: expected %0d, got %0d",
                           due.src_row_done, o_out.src_row_done);
                    n_fail++;
                end
            end
        end
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) upscale_step(i_in);
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pend_items.size() > 0) begin
                i_in     <= pend_items.pop_front();
                i_valid  <= 1'b1;
                gap_left = idle_len(send_quiet);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            stall_left = idle_len(recv_quiet);
        end
    end

    task automatic push_item(t_opcode op, logic [23:0] px, bit counted);
        t_in_item it;
        it.opcode = op;
        {it.in_red, it.in_green, it.in_blue} = px;
        pend_items.push_back(it);
        if (counted) n_stim++;
    endtask

    // stray transfers of the other kind go in front of some of them, at random
    task automatic push_run(t_opcode op, int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 6) begin
                push_item(op == OP_LOAD ? OP_TICK : OP_LOAD, 24'($urandom), 0);
            end
            push_item(op, 24'($urandom), 1);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (pend_items.size() != 0 || i_valid || pixels_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        if (idx == CFG_SCALE) scale_reg = value[6:0];
        else                  width_reg = value[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // only called while idle: finishes the row in flight, then whole rows, the last optionally cut
    task automatic queue_rows(int rows, bit cut_last);
        int w;
        int s;
        int rem;
        int nl;
        int nt;
        int cut_at;
        w = eff_width(width_reg);
        s = eff_scale(scale_reg);
        if (emitting) begin
            rem = (hcopy + 1 >= s) ? 1 : s - hcopy;
            if (col + 1 < w)   rem += (w - col - 1) * s;
            if (vcopy + 1 < s) rem += (s - vcopy - 1) * w * s;
            push_run(OP_TICK, rem);
        end else if (loaded != 0) begin
            push_run(OP_LOAD, loaded < w ? w - loaded : 1);
            push_run(OP_TICK, w * s * s);
        end
        for (int i = 0; i < rows; i++) begin
            nl = w;
            nt = w * s * s;
            if (cut_last && i == rows - 1) begin
                cut_at = $urandom_range(1, nl + nt - 1);
                nl = (cut_at < w) ? cut_at : w;
                nt = cut_at - nl;
            end
            push_run(OP_LOAD, nl);
            push_run(OP_TICK, nt);
        end
    endtask

    function automatic int pick_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(5, 9);
    endfunction

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 0;
        if (r < 80) return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int kind;
        int v;
        int tail;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_SCALE;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_stall    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: tick while loading, full buffer drops a load
        push_item(OP_TICK, 24'h000000, 0);
        push_item(OP_LOAD, 24'hFFFFFF, 0);
        push_item(OP_LOAD, 24'h000000, 0);
        push_item(OP_TICK, 24'h000000, 0);
        wait_idle();
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_SRC_WIDTH, 0);
        push_item(OP_LOAD, 24'hA5C35A, 0);
        push_item(OP_TICK, 24'h5A3CA5, 0);
        wait_idle();
        // width lowered under the loaded count while loading
        write_reg(CFG_SCALE, 2);
        write_reg(CFG_SRC_WIDTH, 5);
        push_item(OP_LOAD, 24'h123456, 0);
        push_item(OP_LOAD, 24'hFEDCBA, 0);
        push_item(OP_LOAD, 24'h0F0F0F, 0);
        wait_idle();
        write_reg(CFG_SRC_WIDTH, 2);
        push_item(OP_TICK, 24'h000000, 0);
        push_item(OP_LOAD, 24'hFFFFFF, 0);
        repeat (3) push_item(OP_TICK, 24'h000000, 0);
        wait_idle();
        // scale lowered mid-row
        write_reg(CFG_SCALE, 1);
        queue_rows(0, 0);
        wait_idle();
        write_reg(CFG_SCALE, 3);
        write_reg(CFG_SRC_WIDTH, 1);
        push_item(OP_LOAD, 24'hC0FFEE, 0);
        repeat (2) push_item(OP_TICK, 24'h000000, 0);
        wait_idle();
        write_reg(CFG_SCALE, 2);
        queue_rows(0, 0);

        // register extremes: clamped width fills at 1024, then cut short
        wait_idle();
        write_reg(CFG_SCALE, 1);
        write_reg(CFG_SRC_WIDTH, 2047);
        push_run(OP_LOAD, MAX_W + 1);
        push_run(OP_TICK, 3);
        wait_idle();
        write_reg(CFG_SRC_WIDTH, 3);
        queue_rows(0, 0);
        // clamped scale: two full output rows, then scale lowered
        wait_idle();
        write_reg(CFG_SCALE, 127);
        write_reg(CFG_SRC_WIDTH, 1);
        push_run(OP_LOAD, 1);
        push_run(OP_TICK, 2 * MAX_S + 2);
        wait_idle();
        write_reg(CFG_SCALE, 1);
        queue_rows(0, 0);

        // long receiver hold while the sender keeps offering transfers
        wait_idle();
        send_quiet = 1;
        recv_quiet = 1;
        write_reg(CFG_SCALE, 3);
        write_reg(CFG_SRC_WIDTH, 6);
        queue_rows(2, 0);
        hold_req = 1;

        while (n_stim < 1550) begin
            wait_idle();
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 2);
            if (kind != 1) write_reg(CFG_SCALE, pick_scale());
            if (kind != 0) begin
                v = pick_width();
                if (emitting && eff_width(v) > high_water) v = high_water;
                write_reg(CFG_SRC_WIDTH, v);
            end
            v = eff_width(width_reg) * eff_scale(scale_reg) * eff_scale(scale_reg);
            queue_rows(v > 200 ? 1 : $urandom_range(1, 3),
                       (v > 200) || ($urandom_range(0, 3) == 0));
        end

        do begin
            @(negedge i_clk);
            #1;
        end while (pend_items.size() != 0 || i_valid);
        tail = 0;
        while (pixels_due.size() != 0 && tail < 100000) begin
            @(negedge i_clk);
            tail++;
        end
        if (pixels_due.size() != 0) begin
            $error("%0d expected pixels never came out", pixels_due.size());
            n_fail++;
        end
        repeat (10) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
